### src/rvdec_pkg.sv
// Shared types and constants for the RV32I instruction decoder.
// Used by rvdec_decode and rv32i_instruction_decoder_unit; no dependencies.
package rvdec_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [5:0] {
    MN_ILLEGAL = 6'd0,
    MN_LUI     = 6'd1,
    MN_AUIPC   = 6'd2,
    MN_JAL     = 6'd3,
    MN_JALR    = 6'd4,
    MN_BEQ     = 6'd5,
    MN_BNE     = 6'd6,
    MN_BLT     = 6'd7,
    MN_BGE     = 6'd8,
    MN_BLTU    = 6'd9,
    MN_BGEU    = 6'd10,
    MN_LB      = 6'd11,
    MN_LH      = 6'd12,
    MN_LW      = 6'd13,
    MN_LBU     = 6'd14,
    MN_LHU     = 6'd15,
    MN_SB      = 6'd16,
    MN_SH      = 6'd17,
    MN_SW      = 6'd18,
    MN_ADDI    = 6'd19,
    MN_SLTI    = 6'd20,
    MN_SLTIU   = 6'd21,
    MN_XORI    = 6'd22,
    MN_ORI     = 6'd23,
    MN_ANDI    = 6'd24,
    MN_SLLI    = 6'd25,
    MN_SRLI    = 6'd26,
    MN_SRAI    = 6'd27,
    MN_ADD     = 6'd28,
    MN_SUB     = 6'd29,
    MN_SLL     = 6'd30,
    MN_SLT     = 6'd31,
    MN_SLTU    = 6'd32,
    MN_XOR     = 6'd33,
    MN_SRL     = 6'd34,
    MN_SRA     = 6'd35,
    MN_OR      = 6'd36,
    MN_AND     = 6'd37,
    MN_CSRRW   = 6'd38,
    MN_CSRRS   = 6'd39,
    MN_CSRRC   = 6'd40,
    MN_CSRRWI  = 6'd41,
    MN_CSRRSI  = 6'd42,
    MN_CSRRCI  = 6'd43,
    MN_ECALL   = 6'd44,
    MN_EBREAK  = 6'd45
  } mnem_e;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

  // Decoded fields of one item, except the raw register fields.
  typedef struct packed {
    mnem_e            mnemonic;
    logic [XLEN-1:0]  immediate;
    logic [XLEN-1:0]  target;
    logic [11:0]      csr_number;
  } dec_t;

endpackage

### src/rvdec_decode.sv
// Combinational RV32I decode: mnemonic, immediate, pc-relative target, CSR number.
// Depends on rvdec_pkg.
module rvdec_decode (
  input  logic [31:0]         instr_i,
  input  logic [31:0]         pc_i,
  output rvdec_pkg::dec_t     dec_o
);
  import rvdec_pkg::*;

  logic [6:0]      opcode;
  logic [2:0]      funct3;
  logic [6:0]      funct7;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_s;
  logic [XLEN-1:0] imm_b;
  logic [XLEN-1:0] imm_j;
  logic [XLEN-1:0] imm_u;
  logic [XLEN-1:0] imm_sh;
  logic            pc_rel;

  assign opcode = instr_i[6:0];
  assign funct3 = instr_i[14:12];
  assign funct7 = instr_i[31:25];

  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b  = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                   instr_i[11:8], 1'b0};
  assign imm_j  = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                   instr_i[30:21], 1'b0};
  assign imm_u  = {12'd0, instr_i[31:12]};
  assign imm_sh = {27'd0, instr_i[24:20]};

  always_comb begin
    dec_o.mnemonic   = MN_ILLEGAL;
    dec_o.immediate  = '0;
    dec_o.csr_number = '0;
    pc_rel           = 1'b0;

    // The two exact system words win over the opcode decode.
    if (instr_i == WORD_ECALL) begin
      dec_o.mnemonic = MN_ECALL;
    end else if (instr_i == WORD_EBREAK) begin
      dec_o.mnemonic = MN_EBREAK;
    end else begin
      case (opcode)
        OPC_LUI: begin
          dec_o.mnemonic  = MN_LUI;
          dec_o.immediate = imm_u;
        end
        OPC_AUIPC: begin
          dec_o.mnemonic  = MN_AUIPC;
          dec_o.immediate = imm_u;
        end
        OPC_JAL: begin
          dec_o.mnemonic  = MN_JAL;
          dec_o.immediate = imm_j;
          pc_rel          = 1'b1;
        end
        OPC_JALR: begin
          dec_o.mnemonic  = MN_JALR;
          dec_o.immediate = imm_i;
        end
        OPC_BRANCH: begin
          case (funct3)
            3'd0:    dec_o.mnemonic = MN_BEQ;
            3'd1:    dec_o.mnemonic = MN_BNE;
            3'd4:    dec_o.mnemonic = MN_BLT;
            3'd5:    dec_o.mnemonic = MN_BGE;
            3'd6:    dec_o.mnemonic = MN_BLTU;
            3'd7:    dec_o.mnemonic = MN_BGEU;
            default: dec_o.mnemonic = MN_ILLEGAL;
          endcase
          if (dec_o.mnemonic != MN_ILLEGAL) begin
            dec_o.immediate = imm_b;
            pc_rel          = 1'b1;
          end
        end
        OPC_LOAD: begin
          case (funct3)
            3'd0:    dec_o.mnemonic = MN_LB;
            3'd1:    dec_o.mnemonic = MN_LH;
            3'd2:    dec_o.mnemonic = MN_LW;
            3'd4:    dec_o.mnemonic = MN_LBU;
            3'd5:    dec_o.mnemonic = MN_LHU;
            default: dec_o.mnemonic = MN_ILLEGAL;
          endcase
          if (dec_o.mnemonic != MN_ILLEGAL) begin
            dec_o.immediate = imm_i;
          end
        end
        OPC_STORE: begin
          case (funct3)
            3'd0:    dec_o.mnemonic = MN_SB;
            3'd1:    dec_o.mnemonic = MN_SH;
            3'd2:    dec_o.mnemonic = MN_SW;
            default: dec_o.mnemonic = MN_ILLEGAL;
          endcase
          if (dec_o.mnemonic != MN_ILLEGAL) begin
            dec_o.immediate = imm_s;
          end
        end
        OPC_OPIMM: begin
          case (funct3)
            3'd0: begin
              dec_o.mnemonic  = MN_ADDI;
              dec_o.immediate = imm_i;
            end
            3'd1: begin
              // slli does not look at funct7.
              dec_o.mnemonic  = MN_SLLI;
              dec_o.immediate = imm_sh;
            end
            3'd2: begin
              dec_o.mnemonic  = MN_SLTI;
              dec_o.immediate = imm_i;
            end
            3'd3: begin
              dec_o.mnemonic  = MN_SLTIU;
              dec_o.immediate = imm_i;
            end
            3'd4: begin
              dec_o.mnemonic  = MN_XORI;
              dec_o.immediate = imm_i;
            end
            3'd5: begin
              if (funct7 == F7_BASE) begin
                dec_o.mnemonic  = MN_SRLI;
                dec_o.immediate = imm_sh;
              end else if (funct7 == F7_ALT) begin
                dec_o.mnemonic  = MN_SRAI;
                dec_o.immediate = imm_sh;
              end
            end
            3'd6: begin
              dec_o.mnemonic  = MN_ORI;
              dec_o.immediate = imm_i;
            end
            default: begin
              dec_o.mnemonic  = MN_ANDI;
              dec_o.immediate = imm_i;
            end
          endcase
        end
        OPC_OP: begin
          case (funct3)
            3'd0: begin
              if (funct7 == F7_BASE) begin
                dec_o.mnemonic = MN_ADD;
              end else if (funct7 == F7_ALT) begin
                dec_o.mnemonic = MN_SUB;
              end
            end
            3'd1: dec_o.mnemonic = MN_SLL;
            3'd2: dec_o.mnemonic = MN_SLT;
            3'd3: dec_o.mnemonic = MN_SLTU;
            3'd4: dec_o.mnemonic = MN_XOR;
            3'd5: begin
              if (funct7 == F7_BASE) begin
                dec_o.mnemonic = MN_SRL;
              end else if (funct7 == F7_ALT) begin
                dec_o.mnemonic = MN_SRA;
              end
            end
            3'd6:    dec_o.mnemonic = MN_OR;
            default: dec_o.mnemonic = MN_AND;
          endcase
        end
        OPC_SYSTEM: begin
          case (funct3)
            3'd1:    dec_o.mnemonic = MN_CSRRW;
            3'd2:    dec_o.mnemonic = MN_CSRRS;
            3'd3:    dec_o.mnemonic = MN_CSRRC;
            3'd5:    dec_o.mnemonic = MN_CSRRWI;
            3'd6:    dec_o.mnemonic = MN_CSRRSI;
            3'd7:    dec_o.mnemonic = MN_CSRRCI;
            default: dec_o.mnemonic = MN_ILLEGAL;
          endcase
          if (dec_o.mnemonic != MN_ILLEGAL) begin
            dec_o.csr_number = instr_i[31:20];
          end
        end
        default: begin
          dec_o.mnemonic = MN_ILLEGAL;
        end
      endcase
    end

    // Only jal and branches carry a target; the add wraps modulo 2^32.
    dec_o.target = pc_rel ? (pc_i + dec_o.immediate) : '0;
  end

endmodule

### src/rv32i_instruction_decoder_unit.sv
// RV32I instruction decoder: input register, decode logic, output register.
// Each item passes the input register, the decode, then the output register.
// Throughput: one item per cycle unless out_ready_i stalls; the output register ready
// drives the input register ready, which drives in_ready_o, so a stall backs up to the input.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not reset.
// Depends on rvdec_pkg and rvdec_decode.
module rv32i_instruction_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instruction_i,
  input  logic [31:0]        pc_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         mnemonic_o,
  output logic [4:0]         rd_o,
  output logic [4:0]         rs1_o,
  output logic [4:0]         rs2_o,
  output logic signed [31:0] immediate_o,
  output logic [31:0]        target_o,
  output logic [11:0]        csr_number_o,
  output logic               legal_o
);
  import rvdec_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_instr_q;
  logic [31:0] s1_pc_q;
  logic        s1_ready;

  logic        out_valid_q, out_valid_d;
  logic        out_ready;
  dec_t        dec;
  dec_t        out_dec_q;
  logic [14:0] out_regs_q;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  rvdec_decode u_decode (
    .instr_i (s1_instr_q),
    .pc_i    (s1_pc_q),
    .dec_o   (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_instr_q <= instruction_i;
      s1_pc_q    <= pc_i;
    end
    if (s1_valid_q && out_ready) begin
      out_dec_q  <= dec;
      out_regs_q <= {s1_instr_q[11:7], s1_instr_q[19:15], s1_instr_q[24:20]};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mnemonic_o   = out_dec_q.mnemonic;
  assign rd_o         = out_regs_q[14:10];
  assign rs1_o        = out_regs_q[9:5];
  assign rs2_o        = out_regs_q[4:0];
  assign immediate_o  = $signed(out_dec_q.immediate);
  assign target_o     = out_dec_q.target;
  assign csr_number_o = out_dec_q.csr_number;
  assign legal_o      = (out_dec_q.mnemonic != MN_ILLEGAL);

`ifndef SYNTHESIS
  // A target only ever comes with jal or a branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o != '0) |->
      (mnemonic_o == MN_JAL) || (mnemonic_o == MN_BEQ) || (mnemonic_o == MN_BNE) ||
      (mnemonic_o == MN_BLT) || (mnemonic_o == MN_BGE) || (mnemonic_o == MN_BLTU) ||
      (mnemonic_o == MN_BGEU))
    else $error("target set for a non pc-relative item");

  // An illegal item carries no immediate and no CSR number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !legal_o |-> (immediate_o == '0) && (csr_number_o == '0))
    else $error("illegal item carries decoded fields");

  // An item held in the input stage moves on whenever the output stage frees up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_ready |=> out_valid_q)
    else $error("item lost between input and output stage");

  // A stalled result stays on the outputs unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_dec_q) && $stable(out_regs_q))
    else $error("stalled result changed");
`endif

endmodule
